FILE: rtl/html_tag_stripper_core_defines.svh
// Assertion macros shared by the checker files of the tag stripper.
`ifndef HTML_TAG_STRIPPER_CORE_DEFINES_SVH
`define HTML_TAG_STRIPPER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define HTS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("html_tag_stripper_core: check failed");

// Next-cycle implication, ignored while reset is asserted.
`define HTS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("html_tag_stripper_core: check failed");

// Next-cycle implication that is also checked across reset.
`define HTS_ASSERT_RST(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("html_tag_stripper_core: reset check failed");

`endif

FILE: rtl/hts_pkg.sv
// Types, constants and name tables shared by the tag stripper modules.
package hts_pkg;

    localparam int NAME_DEPTH  = 8;
    localparam int NUM_IGNORE  = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic [7:0] IGNORE_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_of_document;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  plain_byte;
        logic [31:0] byte_position;
        logic        run_start;
    } t_out_beat;

    // What the back end does with one document byte.
    typedef enum logic [1:0] {
        OP_SKIP,
        OP_EMIT,
        OP_BREAK
    } t_op;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       restart;
        t_op        op;
    } t_cmd;

    typedef struct packed {
        logic has_room;
        logic has_data;
    } t_q_stat;

    // Ignored element names, left aligned, zero padded to eight bytes.
    function automatic logic [63:0] ignore_word(input logic [2:0] tag);
        logic [63:0] w;
        case (tag)
            3'd0:    w = {"canvas", 16'h0};
            3'd1:    w = {"math", 32'h0};
            3'd2:    w = "noscript";
            3'd3:    w = {"object", 16'h0};
            3'd4:    w = {"script", 16'h0};
            3'd5:    w = {"style", 24'h0};
            3'd6:    w = {"svg", 40'h0};
            3'd7:    w = "template";
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] ignore_char(input logic [2:0] tag, input logic [2:0] pos);
        logic [63:0] w;
        w = ignore_word(tag);
        return w[8 * (7 - int'(pos)) +: 8];
    endfunction

    function automatic logic [3:0] ignore_len(input logic [2:0] tag);
        logic [3:0] n;
        case (tag)
            3'd0:    n = 4'd6;
            3'd1:    n = 4'd4;
            3'd2:    n = 4'd8;
            3'd3:    n = 4'd6;
            3'd4:    n = 4'd6;
            3'd5:    n = 4'd5;
            3'd6:    n = 4'd3;
            3'd7:    n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B
            || c == 8'h0C || c == 8'h0D;
    endfunction

endpackage

FILE: rtl/hts_front.sv
// Front end: takes document bytes, runs the tag parser and classifies each byte.
module hts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    input  hts_pkg::t_in_beat i_beat,
    input  hts_pkg::t_q_stat  i_stat,
    output logic              o_ready,
    output logic              o_push,
    output hts_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_TAG_START,
        MODE_TAG_NAME,
        MODE_TAG_REST,
        MODE_COMMENT
    } t_mode;

    t_mode       r_mode, n_mode;
    logic        r_closing, n_closing;
    logic [3:0]  r_len, n_len;
    logic        r_ovf, n_ovf;
    logic [7:0]  r_prev;
    logic [1:0]  r_dash, n_dash;
    logic        r_ign, n_ign;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_match, n_match;
    logic        r_bang, n_bang;
    logic [7:0]  r_mask;

    // Parser state after a document restart is applied.
    t_mode       c_mode;
    logic        c_closing, c_ovf, c_ign, c_bang;
    logic [3:0]  c_len;
    logic [7:0]  c_prev, c_match;
    logic [1:0]  c_dash;
    logic [2:0]  c_idx;

    logic [7:0]  ch, lc;
    logic [7:0]  tag_hit;
    logic        start_hit;
    logic [2:0]  start_idx;
    logic        fin_ign;
    logic [2:0]  fin_idx;
    logic [3:0]  st_len;
    logic        st_ovf, st_bang, st_comment;
    logic [7:0]  st_match;
    logic        is_gt;
    hts_pkg::t_op op;

    assign o_ready = i_stat.has_room;
    assign o_push  = i_valid && i_stat.has_room;
    assign ch      = i_beat.text_byte;
    assign lc      = hts_pkg::to_lower(ch);
    assign is_gt   = (ch == hts_pkg::CH_GT);

    always_comb begin
        if (i_beat.first_of_document) begin
            c_mode    = MODE_TEXT;
            c_closing = 1'b0;
            c_len     = '0;
            c_ovf     = 1'b0;
            c_prev    = '0;
            c_dash    = '0;
            c_ign     = 1'b0;
            c_idx     = '0;
            c_match   = '1;
            c_bang    = 1'b1;
        end else begin
            c_mode    = r_mode;
            c_closing = r_closing;
            c_len     = r_len;
            c_ovf     = r_ovf;
            c_prev    = r_prev;
            c_dash    = r_dash;
            c_ign     = r_ign;
            c_idx     = r_idx;
            c_match   = r_match;
            c_bang    = r_bang;
        end
    end

    // Tag close: eight name compares and the ignore start/stop decision.
    always_comb begin
        for (int i = 0; i < hts_pkg::NUM_IGNORE; i++) begin
            tag_hit[i] = !c_ovf && (c_len == hts_pkg::ignore_len(3'(i))) && c_match[i];
        end
        start_hit = 1'b0;
        start_idx = '0;
        for (int i = hts_pkg::NUM_IGNORE - 1; i >= 0; i--) begin
            if (r_mask[i] && tag_hit[i]) begin
                start_hit = 1'b1;
                start_idx = 3'(i);
            end
        end
        fin_ign = c_ign;
        fin_idx = c_idx;
        if (c_prev != hts_pkg::CH_SLASH) begin
            if (!c_ign && !c_closing) begin
                if (start_hit) begin
                    fin_ign = 1'b1;
                    fin_idx = start_idx;
                end
            end else if (c_ign && c_closing) begin
                if (tag_hit[c_idx]) begin
                    fin_ign = 1'b0;
                end
            end
        end
    end

    // Name byte: narrow the candidate set and watch for a comment opening.
    always_comb begin
        st_len   = c_len;
        st_ovf   = c_ovf;
        st_match = c_match;
        st_bang  = c_bang;
        if (c_len < 4'(hts_pkg::NAME_DEPTH)) begin
            for (int i = 0; i < hts_pkg::NUM_IGNORE; i++) begin
                st_match[i] = c_match[i]
                    && (lc == hts_pkg::ignore_char(3'(i), c_len[2:0]));
            end
            if (c_len == 4'd0) begin
                st_bang = c_bang && (ch == hts_pkg::CH_BANG);
            end else if (c_len < 4'd3) begin
                st_bang = c_bang && (ch == hts_pkg::CH_DASH);
            end
            st_len = c_len + 4'd1;
        end else begin
            st_ovf = 1'b1;
        end
        st_comment = !c_closing && !st_ovf && (st_len == 4'd3) && st_bang;
    end

    always_comb begin
        n_mode    = c_mode;
        n_closing = c_closing;
        n_len     = c_len;
        n_ovf     = c_ovf;
        n_dash    = c_dash;
        n_ign     = c_ign;
        n_idx     = c_idx;
        n_match   = c_match;
        n_bang    = c_bang;
        op        = hts_pkg::OP_SKIP;
        case (c_mode)
            MODE_TEXT: begin
                if (ch == hts_pkg::CH_LT) begin
                    n_mode    = MODE_TAG_START;
                    n_closing = 1'b0;
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    n_match   = '1;
                    n_bang    = 1'b1;
                end else if (!c_ign) begin
                    op = hts_pkg::OP_EMIT;
                end
            end
            MODE_TAG_START, MODE_TAG_NAME: begin
                if (c_mode == MODE_TAG_START && ch == hts_pkg::CH_SLASH) begin
                    n_closing = 1'b1;
                    n_mode    = MODE_TAG_NAME;
                end else if (is_gt) begin
                    n_ign     = fin_ign;
                    n_idx     = fin_idx;
                    n_mode    = MODE_TEXT;
                    n_closing = 1'b0;
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    op        = hts_pkg::OP_BREAK;
                end else if (hts_pkg::is_space(ch)) begin
                    n_mode = MODE_TAG_REST;
                end else begin
                    n_len   = st_len;
                    n_ovf   = st_ovf;
                    n_match = st_match;
                    n_bang  = st_bang;
                    if (st_comment) begin
                        n_mode = MODE_COMMENT;
                        n_dash = '0;
                    end else begin
                        n_mode = MODE_TAG_NAME;
                    end
                end
            end
            MODE_TAG_REST: begin
                if (is_gt) begin
                    n_ign     = fin_ign;
                    n_idx     = fin_idx;
                    n_mode    = MODE_TEXT;
                    n_closing = 1'b0;
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    op        = hts_pkg::OP_BREAK;
                end
            end
            MODE_COMMENT: begin
                if (ch == hts_pkg::CH_DASH) begin
                    if (c_dash < 2'd2) begin
                        n_dash = c_dash + 2'd1;
                    end
                end else if (is_gt && c_dash >= 2'd2) begin
                    n_mode    = MODE_TEXT;
                    n_dash    = '0;
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    n_closing = 1'b0;
                    op        = hts_pkg::OP_BREAK;
                end else begin
                    n_dash = '0;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    assign o_cmd.text_byte = ch;
    assign o_cmd.restart   = i_beat.first_of_document;
    assign o_cmd.op        = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_TEXT;
            r_closing <= 1'b0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_prev    <= '0;
            r_dash    <= '0;
            r_ign     <= 1'b0;
            r_idx     <= '0;
            r_match   <= '1;
            r_bang    <= 1'b1;
            r_mask    <= hts_pkg::IGNORE_MASK_RESET;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            if (o_push) begin
                r_mode    <= n_mode;
                r_closing <= n_closing;
                r_len     <= n_len;
                r_ovf     <= n_ovf;
                r_prev    <= ch;
                r_dash    <= n_dash;
                r_ign     <= n_ign;
                r_idx     <= n_idx;
                r_match   <= n_match;
                r_bang    <= n_bang;
            end
        end
    end

endmodule

FILE: rtl/hts_queue.sv
// Short command queue between the parser front end and the output back end.
module hts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hts_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output hts_pkg::t_cmd    o_cmd,
    output hts_pkg::t_q_stat o_stat
);

    localparam int AW = $clog2(hts_pkg::QUEUE_DEPTH);

    hts_pkg::t_cmd r_mem [hts_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_count;

    assign o_cmd           = r_mem[r_rd];
    assign o_stat.has_room = (r_count != (AW + 1)'(hts_pkg::QUEUE_DEPTH));
    assign o_stat.has_data = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/hts_back.sv
// Back end: counts byte positions, marks run starts and holds the output register.
module hts_back #(
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hts_pkg::t_cmd      i_cmd,
    input  hts_pkg::t_q_stat   i_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output hts_pkg::t_out_beat o_beat
);

    logic [POSITION_BITS-1:0]    r_pos, c_pos;
    logic                        r_run, c_run;
    logic                        r_valid;
    hts_pkg::t_out_beat          r_beat;
    logic                        is_emit;
    logic [POSITION_BITS+31:0]   pos_ext;

    assign is_emit = (i_cmd.op == hts_pkg::OP_EMIT);
    assign o_pop   = i_stat.has_data && (!is_emit || !r_valid || i_ready);
    assign c_pos   = i_cmd.restart ? '0 : r_pos;
    assign c_run   = i_cmd.restart ? 1'b1 : r_run;
    assign pos_ext = {32'b0, c_pos};

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (o_pop && is_emit) begin
            r_beat.plain_byte    <= i_cmd.text_byte;
            r_beat.byte_position <= pos_ext[31:0];
            r_beat.run_start     <= c_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
            r_run   <= 1'b1;
        end else begin
            if (o_pop) begin
                r_pos <= c_pos + POSITION_BITS'(1);
                case (i_cmd.op)
                    hts_pkg::OP_EMIT:  r_run <= 1'b0;
                    hts_pkg::OP_BREAK: r_run <= 1'b1;
                    default:           r_run <= c_run;
                endcase
            end
            if (o_pop && is_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/html_tag_stripper_core.sv
// Top level of the HTML tag stripper: front end, command queue and back end.
//
// Input channel: one document byte per beat (i_in_beat) on valid/ready. A beat with
// first_of_document set restarts parsing before its byte is taken: text mode, no
// ignored element, position zero. Output channel: one beat per text byte that lies
// outside tags, comments and ignored elements, with its document position and a
// run-start mark. Tags, comments and ignored text produce no output beat at all.
// Configuration: i_cfg_we writes i_cfg_data into the ignore mask; write
// it only while the block is idle. Bit order: canvas, math, noscript, object,
// script, style, svg, template.
// Throughput is one byte per cycle while the queue has room and the output is not
// stalled: the parser decides each byte as it is accepted, and the back end
// drains one queued byte per cycle unless a text byte waits on a held output
// register. Accepted bytes are queued; text bytes move on to the output register.
// When the receiver stalls, the output register holds its beat and the four-beat
// queue keeps taking input; o_in_ready drops only when the queue is full.
// Synchronous reset empties the queue and the output register, clears the parser
// state and sets the ignore mask to all ones. There is no clearing pass.
module html_tag_stripper_core #(
    parameter int POSITION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hts_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hts_pkg::t_out_beat o_out_beat
);

    // Front-end classification of each accepted byte, one queue entry per byte.
    hts_pkg::t_cmd    push_cmd;
    hts_pkg::t_cmd    head_cmd;
    hts_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;

    // The parser updates its state on every accepted beat, so every byte
    // advances the position even when it is swallowed.
    hts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .i_beat     (i_in_beat),
        .i_stat     (q_stat),
        .o_ready    (o_in_ready),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // The queue lets the parser run ahead while the output side is stalled.
    hts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // Swallowed bytes leave the queue at once; text bytes wait for the
    // output register to be free or drained in the same cycle.
    hts_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

endmodule

FILE: rtl/hts_checker.sv
// Port-level checks for the HTML tag stripper and their bind to the top level.
`include "html_tag_stripper_core_defines.svh"

module hts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input hts_pkg::t_out_beat o_out_beat
);

    // A stalled output beat stays presented and unchanged.
    `HTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_beat))

    // A tag opener never leaves the block as text.
    `HTS_ASSERT_IMP(a_no_lt, i_clk, i_rst_n, o_out_valid, o_out_beat.plain_byte != hts_pkg::CH_LT)

    // Reset empties the output register.
    `HTS_ASSERT_RST(a_rst_out, i_clk, !i_rst_n, !o_out_valid)

    // Reset empties the queue, so input is taken right after it.
    `HTS_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n, o_in_ready)

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (.*);
